>>> rtl/core/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg
// Shared types and sizes for the sorted list intersection counter.
// ----------------------------------------------------------------------------
package sic_pkg;

	localparam int MAX_LIST_LEN = 1024;
	localparam int ID_WIDTH     = 32;
	localparam int ADDR_W       = $clog2(MAX_LIST_LEN);
	localparam int LEN_W        = $clog2(MAX_LIST_LEN + 1);
	localparam int FIELD_W      = 32;
	localparam int COUNT_W      = 11;
	localparam int MODE_W       = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD_A  = 2'd0,
		MODE_LOAD_B  = 2'd1,
		MODE_COMPUTE = 2'd2
	} sic_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_COMPARE,
		ST_RESULT
	} sic_state_t;

	typedef struct packed {
		logic [COUNT_W-1:0] match_count;
		logic               overflow;
	} sic_result_t;

endpackage

>>> rtl/core/sic_merge_core.sv
// ----------------------------------------------------------------------------
// sic_merge_core
// Two list memories, their fill counts and the merge sequencer that walks
// both lists with one shared comparator, each step a fetch state then a compare state.
// ----------------------------------------------------------------------------
module sic_merge_core import sic_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [MODE_W-1:0]  in_mode,
	input  logic [FIELD_W-1:0] in_value,
	input  logic [FIELD_W-1:0] in_ex1,
	input  logic [FIELD_W-1:0] in_ex2,
	output logic               res_valid,
	input  logic               res_ready,
	output sic_result_t        res
);

	logic [ID_WIDTH-1:0] mem_a [MAX_LIST_LEN];
	logic [ID_WIDTH-1:0] mem_b [MAX_LIST_LEN];

	sic_state_t          state_q, state_d;
	logic [LEN_W-1:0]    len_a_q, len_b_q;
	logic [LEN_W-1:0]    ia_q, ib_q;
	logic [COUNT_W-1:0]  hits_q;
	logic                ovf_q;
	logic [ID_WIDTH-1:0] ex1_q, ex2_q;
	logic [ID_WIDTH-1:0] rd_a_q, rd_b_q;

	logic accept, wr_a, wr_b, start, finish;
	logic both_left, eq, lt, hit;

	assign accept = in_valid && in_ready;
	assign wr_a   = accept && (in_mode == MODE_LOAD_A) && (len_a_q < LEN_W'(MAX_LIST_LEN));
	assign wr_b   = accept && (in_mode == MODE_LOAD_B) && (len_b_q < LEN_W'(MAX_LIST_LEN));
	assign start  = accept && (in_mode == MODE_COMPUTE);

	assign both_left = (ia_q < len_a_q) && (ib_q < len_b_q);

	// shared compare unit
	assign eq  = (rd_a_q == rd_b_q);
	assign lt  = (rd_a_q < rd_b_q);
	assign hit = eq && (rd_a_q != ex1_q) && (rd_a_q != ex2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (start) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = both_left ? ST_COMPARE : ST_RESULT;
			end
			ST_COMPARE: begin
				state_d = ST_FETCH;
			end
			ST_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= '0;
			len_b_q <= '0;
			ovf_q   <= 1'b0;
			ia_q    <= '0;
			ib_q    <= '0;
			hits_q  <= '0;
		end else begin
			if (wr_a) begin
				len_a_q <= len_a_q + LEN_W'(1);
			end
			if (wr_b) begin
				len_b_q <= len_b_q + LEN_W'(1);
			end
			// load into a full list is dropped
			if (accept && !wr_a && !wr_b &&
			    ((in_mode == MODE_LOAD_A) || (in_mode == MODE_LOAD_B))) begin
				ovf_q <= 1'b1;
			end
			if (start) begin
				ia_q   <= '0;
				ib_q   <= '0;
				hits_q <= '0;
			end
			if (state_q == ST_COMPARE) begin
				if (hit) begin
					hits_q <= hits_q + COUNT_W'(1);
					ia_q   <= ia_q + LEN_W'(1);
					ib_q   <= ib_q + LEN_W'(1);
				end else if (lt) begin
					ia_q <= ia_q + LEN_W'(1);
				end else begin
					ib_q <= ib_q + LEN_W'(1);
				end
			end
			if (finish) begin
				len_a_q <= '0;
				len_b_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ex1_q <= in_ex1[ID_WIDTH-1:0];
			ex2_q <= in_ex2[ID_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[len_a_q[ADDR_W-1:0]] <= in_value[ID_WIDTH-1:0];
		end
		if (wr_b) begin
			mem_b[len_b_q[ADDR_W-1:0]] <= in_value[ID_WIDTH-1:0];
		end
		rd_a_q <= mem_a[ia_q[ADDR_W-1:0]];
		rd_b_q <= mem_b[ib_q[ADDR_W-1:0]];
	end

	assign res.match_count = hits_q;
	assign res.overflow    = ovf_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len_a_q <= LEN_W'(MAX_LIST_LEN)) && (len_b_q <= LEN_W'(MAX_LIST_LEN)))
		else $error("list length beyond capacity");

	a_cmp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPARE) |-> ((ia_q < len_a_q) && (ib_q < len_b_q)))
		else $error("compare past end of a list");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> ((len_a_q == '0) && (len_b_q == '0) && !ovf_q))
		else $error("lists not emptied after result");

	a_hits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ((LEN_W'(hits_q) <= ia_q) && (LEN_W'(hits_q) <= ib_q)))
		else $error("match count ahead of list index");

	a_fetch_after_compare: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPARE) |=> (state_q == ST_FETCH))
		else $error("merge step did not return to fetch");

endmodule

>>> rtl/core/sorted_intersection_count_top.sv
// ----------------------------------------------------------------------------
// sorted_intersection_count_top
// Counts shared identifiers of two ascending lists, skipping two excluded ids.
// ----------------------------------------------------------------------------
// usage
//   slave side takes one word per item: tuser holds the mode, tdata the
//   value and the two excluded ids. mode 0 appends to list a, mode 1 to
//   list b, mode 2 computes, mode 3 is ignored.
//   loads give no result; a load into a full list is dropped and sets the
//   overflow flag.
//   a compute word runs the merge: each merge step is one registered read
//   of both list memories, then one pass through the shared comparator;
//   the merge runs at most len_a + len_b steps before the result word
//   reaches the output register.
//   tready stays low while the merge runs.
//   master side gives one word per compute: count and overflow flag; both
//   lists and the flag are then emptied.
//   if the receiver stalls, the result waits in the output register; loads
//   are still taken, and a further compute finishes its merge and holds
//   until the register frees.
//   reset empties both lists, clears the flag and drops any pending word.
// ----------------------------------------------------------------------------
module sorted_intersection_count_top import sic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,   // node_value, exclude_first, exclude_second
	input  logic [7:0]  s_axis_tuser,   // mode, zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // match_count, zero fill
	output logic [7:0]  m_axis_tuser    // overflow, zero fill
);

	logic        res_valid, res_ready;
	sic_result_t res;
	logic        out_valid_q;
	sic_result_t out_q;

	sic_merge_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser[MODE_W-1:0]),
		.in_value  (s_axis_tdata[FIELD_W-1:0]),
		.in_ex1    (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
		.in_ex2    (s_axis_tdata[3*FIELD_W-1:2*FIELD_W]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(16-COUNT_W){1'b0}}, out_q.match_count};
	assign m_axis_tuser  = {7'd0, out_q.overflow};

endmodule

>>> tb/sv/tb_sorted_intersection_count_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_intersection_count_top
// Self-checking bench for the sorted list intersection counter.
// Load, compute and ignored words go in on the slave side with random gaps.
// A scoreboard keeps its own copy of both lists and predicts each result
// word. It compares every result word against the oldest prediction.
// ----------------------------------------------------------------------------
import sic_pkg::*;

class intersect_scoreboard;
	logic [ID_WIDTH-1:0] list_a[MAX_LIST_LEN];
	logic [ID_WIDTH-1:0] list_b[MAX_LIST_LEN];
	int                  len_a;
	int                  len_b;
	bit                  dropped;
	sic_result_t         expected_q[$];
	int                  errors;

	function new();
		len_a   = 0;
		len_b   = 0;
		dropped = 1'b0;
		errors  = 0;
	endfunction

	// scalar sorted merge over whatever the lists hold
	function int merge_hits(logic [ID_WIDTH-1:0] ex1, logic [ID_WIDTH-1:0] ex2);
		int ia;
		int ib;
		int hits;
		ia   = 0;
		ib   = 0;
		hits = 0;
		while (ia < len_a && ib < len_b) begin
			if (list_a[ia] == list_b[ib] && list_a[ia] != ex1 && list_a[ia] != ex2) begin
				hits++;
				ia++;
				ib++;
			end else if (list_a[ia] < list_b[ib]) begin
				ia++;
			end else begin
				ib++;
			end
		end
		return hits;
	endfunction

	function void note_word(logic [MODE_W-1:0] mode, logic [FIELD_W-1:0] value,
			logic [FIELD_W-1:0] ex1, logic [FIELD_W-1:0] ex2);
		sic_result_t res;
		int          hits;
		case (mode)
			MODE_LOAD_A: begin
				if (len_a < MAX_LIST_LEN) begin
					list_a[len_a] = value[ID_WIDTH-1:0];
					len_a++;
				end else begin
					dropped = 1'b1;
				end
			end
			MODE_LOAD_B: begin
				if (len_b < MAX_LIST_LEN) begin
					list_b[len_b] = value[ID_WIDTH-1:0];
					len_b++;
				end else begin
					dropped = 1'b1;
				end
			end
			MODE_COMPUTE: begin
				hits            = merge_hits(ex1[ID_WIDTH-1:0], ex2[ID_WIDTH-1:0]);
				res.match_count = hits[COUNT_W-1:0];
				res.overflow    = dropped;
				expected_q      = {expected_q, res};
				len_a   = 0;
				len_b   = 0;
				dropped = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	function void check_result(logic [COUNT_W-1:0] count, logic ovf);
		sic_result_t exp_res;
		if (expected_q.size() == 0) begin
			$display("%0t: result word with none expected, count %0d overflow %0d",
				$time, count, ovf);
			errors++;
			return;
		end
		exp_res = expected_q.pop_front();
		if (count !== exp_res.match_count) begin
			$display("%0t: match_count expected %0d, got %0d",
				$time, exp_res.match_count, count);
			errors++;
		end
		if (ovf !== exp_res.overflow) begin
			$display("%0t: overflow expected %0d, got %0d", $time, exp_res.overflow, ovf);
			errors++;
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb_sorted_intersection_count_top;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 150;
	localparam int HOLD_CYCLES  = 1500;
	localparam int TAIL_CYCLES  = 16;
	localparam int CYCLE_LIMIT  = 1000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [3*FIELD_W-1:0] s_axis_tdata;   // node_value, exclude_first, exclude_second
	logic [7:0]           s_axis_tuser;   // mode, zero fill
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [15:0]          m_axis_tdata;   // match_count, zero fill
	logic [7:0]           m_axis_tuser;   // overflow, zero fill

	intersect_scoreboard sb;
	bit                  calm = 1'b0;
	bit                  request_hold = 1'b0;
	int                  items_sent = 0;

	sorted_intersection_count_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic send_word(input logic [MODE_W-1:0] mode, input logic [FIELD_W-1:0] value,
			input logic [FIELD_W-1:0] ex1, input logic [FIELD_W-1:0] ex2);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ex2, ex1, value};
		s_axis_tuser  <= {{(8-MODE_W){1'b0}}, mode};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(mode, value, ex1, ex2);
		if (mode != MODE_UNUSED)
			items_sent++;
	endtask

	// loads of both lists interleaved at random, order within each kept
	task automatic send_lists(input logic [FIELD_W-1:0] qa[$], input logic [FIELD_W-1:0] qb[$],
			input logic [FIELD_W-1:0] ex1, input logic [FIELD_W-1:0] ex2, input bit noise);
		int ia;
		int ib;
		ia = 0;
		ib = 0;
		while (ia < qa.size() || ib < qb.size()) begin
			if (noise && $urandom_range(0, 9) == 0)
				send_word(MODE_UNUSED, $urandom, $urandom, $urandom);
			if (ib >= qb.size() || (ia < qa.size() && $urandom_range(0, 1) == 1)) begin
				send_word(MODE_LOAD_A, qa[ia], $urandom, $urandom);
				ia++;
			end else begin
				send_word(MODE_LOAD_B, qb[ib], $urandom, $urandom);
				ib++;
			end
		end
		send_word(MODE_COMPUTE, $urandom, ex1, ex2);
	endtask

	// called on the step of the last acceptance, so valid is lowered only once
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic random_run();
		logic [FIELD_W-1:0] qa[$];
		logic [FIELD_W-1:0] qb[$];
		logic [FIELD_W-1:0] shared[$];
		logic [FIELD_W-1:0] v;
		logic [FIELD_W-1:0] ex1;
		logic [FIELD_W-1:0] ex2;
		int                 n;
		int                 pick;
		qa     = {};
		qb     = {};
		shared = {};
		if ($urandom_range(0, 99) < 80) begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 16);
			case ($urandom_range(0, 3))
				0: v = $urandom_range(0, 15);
				1: v = 32'hFFFF_FFFF - $urandom_range(0, 60);
				default: v = $urandom;
			endcase
			repeat (n) begin
				v    = v + $urandom_range(0, 6);
				pick = $urandom_range(0, 9);
				if (pick < 4) begin
					qa     = {qa, v};
					qb     = {qb, v};
					shared = {shared, v};
				end else if (pick < 7) begin
					qa = {qa, v};
				end else begin
					qb = {qb, v};
				end
			end
		end else begin
			repeat ($urandom_range(0, 10)) qa = {qa, FIELD_W'($urandom)};
			repeat ($urandom_range(0, 10)) qb = {qb, FIELD_W'($urandom)};
		end
		ex1 = (shared.size() > 0 && $urandom_range(0, 2) == 0) ?
			shared[$urandom_range(0, shared.size() - 1)] : $urandom;
		ex2 = (shared.size() > 0 && $urandom_range(0, 2) == 0) ?
			shared[$urandom_range(0, shared.size() - 1)] : $urandom;
		send_lists(qa, qb, ex1, ex2, 1'b1);
	endtask

	initial begin : stimulus
		logic [FIELD_W-1:0] qa[$];
		logic [FIELD_W-1:0] qb[$];
		int                 start;
		sb = new();
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both lists empty
		qa = {};
		qb = {};
		send_lists(qa, qb, 32'd0, 32'd0, 1'b0);
		send_word(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// extreme ids, an excluded match advances only list b
		qa = '{32'd0, 32'd5, 32'hFFFF_FFFF};
		qb = '{32'd0, 32'd5, 32'd7, 32'hFFFF_FFFF};
		send_lists(qa, qb, 32'd5, 32'h1234_5678, 1'b0);
		// unsorted lists
		qa = '{32'd9, 32'd3};
		qb = '{32'd3, 32'd9};
		send_lists(qa, qb, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		// list b empty
		qa = '{32'd7, 32'd8};
		qb = {};
		send_lists(qa, qb, $urandom, $urandom, 1'b0);
		// match on the second excluded id
		qa = '{32'd1, 32'd2};
		qb = '{32'd1, 32'd2};
		send_lists(qa, qb, 32'd0, 32'd2, 1'b0);
		drain();

		// receiver holds off while computes keep coming
		request_hold = 1'b1;
		repeat (8) begin
			qa = {};
			qb = {};
			repeat ($urandom_range(1, 3)) qa = {qa, FIELD_W'($urandom_range(0, 7))};
			repeat ($urandom_range(1, 3)) qb = {qb, FIELD_W'($urandom_range(0, 7))};
			send_lists(qa, qb, $urandom, $urandom, 1'b0);
		end
		drain();

		// list a full and one more load into it: overflow set
		qa = {};
		qb = {};
		for (int i = 0; i < MAX_LIST_LEN; i++) begin
			qa = {qa, FIELD_W'(16 + 3 * i)};
		end
		qa = {qa, 32'd5};
		for (int i = 0; i < 16; i++) begin
			qb = {qb, FIELD_W'(16 + 192 * i)};
		end
		send_lists(qa, qb, 32'd0, 32'hFFFF_FFFF, 1'b0);
		drain();

		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				calm = !calm;
			random_run();
			if ($urandom_range(0, 29) == 0)
				drain();
		end
		calm = 1'b0;
		drain();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : result_side
		int stall_left;
		stall_left = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata[COUNT_W-1:0], m_axis_tuser[0]);
			if (request_hold) begin
				request_hold = 1'b0;
				stall_left   = HOLD_CYCLES;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule
